@@ rtl/arcp_pkg.sv @@
package arcp_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int MAX_RADIUS    = 64;
  localparam int SQRT_STEPS    = 4;   // root bits resolved per square-root stage

  localparam int POS_W    = 7;
  localparam int RADIUS_W = 7;
  localparam int STROKE_W = 6;
  localparam int CHAN_W   = 8;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    REG_RING_RADIUS = 3'd0,
    REG_RING_WIDTH  = 3'd1,
    REG_COLOR_RED   = 3'd2,
    REG_COLOR_GREEN = 3'd3,
    REG_COLOR_BLUE  = 3'd4,
    REG_COLOR_ALPHA = 3'd5
  } reg_idx_t;

endpackage

@@ rtl/arcp_isqrt.sv @@
module arcp_isqrt import arcp_pkg::*; #(
  parameter int ROOT_W = FRAC_BITS_DEF + 8,
  parameter int STEPS  = SQRT_STEPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  out_valid,
  output logic [ROOT_W-1:0]     root
);

  localparam int NST   = (ROOT_W + STEPS - 1) / STEPS;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic              vld_q  [0:NST];
  logic [RAD_W-1:0]  rad_q  [0:NST];
  logic [REM_W-1:0]  rem_q  [0:NST];
  logic [ROOT_W-1:0] root_q [0:NST];

  assign vld_q[0]  = in_valid;
  assign rad_q[0]  = radicand;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RAD_W-1:0]  rad_next;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // restoring digit recurrence, two radicand bits per root bit
    always_comb begin
      logic [REM_W-1:0] trial;
      rad_next  = rad_q[s];
      rem_next  = rem_q[s];
      root_next = root_q[s];
      trial     = '0;
      for (int k = 0; k < STEPS; k++) begin
        if (s * STEPS + k < ROOT_W) begin
          rem_next = {rem_next[REM_W-3:0], rad_next[RAD_W-1 -: 2]};
          rad_next = {rad_next[RAD_W-3:0], 2'b00};
          trial    = {1'b0, root_next, 2'b01};
          if (rem_next >= trial) begin
            rem_next  = rem_next - trial;
            root_next = {root_next[ROOT_W-2:0], 1'b1};
          end else begin
            root_next = {root_next[ROOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
      rad_q[s+1]  <= rad_next;
      rem_q[s+1]  <= rem_next;
      root_q[s+1] <= root_next;
    end
  end

  assign out_valid = vld_q[NST];
  assign root      = root_q[NST];

endmodule

@@ rtl/antialiased_ring_corner_pixel.sv @@
// Anti-aliased ring pixel generator for a 2R x 2R tile.
// Input: pulse start with pos_x/pos_y; a transaction is taken on every cycle in
// which start is high and busy is low. busy is never raised: one pixel per clock.
// Output: done marks one cycle in which out_red/green/blue/alpha hold the
// premultiplied RGBA pixel; the receiver cannot stall, results come in input order.
// Pipeline from accept to done: abs/square, then the square root with one pipeline
// stage per four root bits, then distance-to-ring, coverage, alpha scale, channel
// scale and output register.
// Throughput: one pixel per cycle, sustained.
// Configuration: APB port, registers at byte addresses 0,4,..,20 (radius, stroke
// width, red, green, blue, alpha). Write only while no pixel is in flight.
// Reset: synchronous rst empties the pipeline (no done pulses) and loads the
// register defaults: radius 16, width 2, opaque white.
module antialiased_ring_corner_pixel import arcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [POS_W-1:0]  pos_x,
  input  logic [POS_W-1:0]  pos_y,
  output logic              done,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_blue,
  output logic [CHAN_W-1:0] out_alpha,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int ROOT_W = FRAC_BITS + 8;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int DM_W   = ROOT_W + 2;
  localparam int T_W    = DM_W + 1;
  localparam logic [8:0]     MAX_RADIUS_V = 9'(MAX_RADIUS);
  localparam logic [T_W-1:0] ONE_V  = T_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0] HALF_V = T_W'(1) << (FRAC_BITS - 1);

  // ---------------- configuration registers ----------------
  logic [RADIUS_W-1:0] ring_radius;
  logic [STROKE_W-1:0] ring_width;
  logic [CHAN_W-1:0]   color_red, color_green, color_blue, color_alpha;
  logic                wr_en;
  reg_idx_t            reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_radius <= RADIUS_W'(16);
      ring_width  <= STROKE_W'(2);
      color_red   <= '1;
      color_green <= '1;
      color_blue  <= '1;
      color_alpha <= '1;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RING_RADIUS: ring_radius <= pwdata[RADIUS_W-1:0];
        REG_RING_WIDTH:  ring_width  <= pwdata[STROKE_W-1:0];
        REG_COLOR_RED:   color_red   <= pwdata[CHAN_W-1:0];
        REG_COLOR_GREEN: color_green <= pwdata[CHAN_W-1:0];
        REG_COLOR_BLUE:  color_blue  <= pwdata[CHAN_W-1:0];
        REG_COLOR_ALPHA: color_alpha <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RING_RADIUS: prdata = DATA_W'(ring_radius);
      REG_RING_WIDTH:  prdata = DATA_W'(ring_width);
      REG_COLOR_RED:   prdata = DATA_W'(color_red);
      REG_COLOR_GREEN: prdata = DATA_W'(color_green);
      REG_COLOR_BLUE:  prdata = DATA_W'(color_blue);
      REG_COLOR_ALPHA: prdata = DATA_W'(color_alpha);
      default:         prdata = '0;
    endcase
  end

  logic [RADIUS_W-1:0] r_sat;
  assign r_sat = ({2'b00, ring_radius} > MAX_RADIUS_V) ? MAX_RADIUS_V[RADIUS_W-1:0]
                                                       : ring_radius;

  // ---------------- stage 1: offsets in half pixels ----------------
  logic signed [9:0] dx2, dy2;
  logic [7:0]        adx_q, ady_q;
  logic              v1_q;

  assign dx2 = $signed({2'b00, pos_x, 1'b1}) - $signed({2'b00, r_sat, 1'b0});
  assign dy2 = $signed({2'b00, pos_y, 1'b1}) - $signed({2'b00, r_sat, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
    end
    adx_q <= dx2[9] ? 8'(-dx2) : dx2[7:0];
    ady_q <= dy2[9] ? 8'(-dy2) : dy2[7:0];
  end

  // ---------------- stage 2: squared distance ----------------
  logic [15:0] sqx, sqy;
  logic [16:0] sq_q;
  logic        v2_q;

  assign sqx = 16'(adx_q) * 16'(adx_q);
  assign sqy = 16'(ady_q) * 16'(ady_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
    sq_q <= {1'b0, sqx} + {1'b0, sqy};
  end

  // ---------------- square root pipeline ----------------
  logic [RAD_W-1:0]  radicand;
  logic [ROOT_W-1:0] root_dist;
  logic              vs_q;

  assign radicand = RAD_W'({sq_q, {(2*FRAC_BITS-2){1'b0}}});

  arcp_isqrt #(
    .ROOT_W (ROOT_W),
    .STEPS  (SQRT_STEPS)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2_q),
    .radicand  (radicand),
    .out_valid (vs_q),
    .root      (root_dist)
  );

  // ---------------- P1: distance from ring mid-line ----------------
  logic [DM_W-1:0]        halfw, rone;
  logic signed [DM_W-1:0] dm;
  logic [DM_W-2:0]        dm_abs_q;
  logic                   p1_q;

  assign halfw = DM_W'({ring_width, {(FRAC_BITS-1){1'b0}}});
  assign rone  = DM_W'({r_sat, {FRAC_BITS{1'b0}}});
  assign dm    = $signed({2'b00, root_dist}) - $signed(rone) + $signed(halfw);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_q <= 1'b0;
    end else begin
      p1_q <= vs_q;
    end
    dm_abs_q <= dm[DM_W-1] ? (DM_W-1)'(-dm) : dm[DM_W-2:0];
  end

  // ---------------- P2: coverage 0..256 ----------------
  logic signed [T_W-1:0] t;
  logic [T_W-1:0]        t_clamp, covf_full;
  logic [FRAC_BITS+8:0]  cov_wide;
  logic [8:0]            cov_q;
  logic                  p2_q;

  assign t = $signed(T_W'(dm_abs_q)) - $signed(T_W'(halfw)) + $signed(HALF_V);

  always_comb begin
    priority if (t[T_W-1]) begin
      t_clamp = '0;
    end else if (t > $signed(ONE_V)) begin
      t_clamp = ONE_V;
    end else begin
      t_clamp = t;
    end
  end

  assign covf_full = ONE_V - t_clamp;
  assign cov_wide  = {covf_full[FRAC_BITS:0], 8'b0} >> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_q <= 1'b0;
    end else begin
      p2_q <= p1_q;
    end
    cov_q <= cov_wide[8:0];
  end

  // ---------------- P3: coverage times opacity ----------------
  logic [15:0] ca_q;
  logic        p3_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_q <= 1'b0;
    end else begin
      p3_q <= p2_q;
    end
    ca_q <= 16'(cov_q) * 16'(color_alpha);
  end

  // ---------------- P4: channel products ----------------
  logic [23:0]       prod_r_q, prod_g_q, prod_b_q;
  logic [CHAN_W-1:0] alpha_q;
  logic              p4_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_q <= 1'b0;
    end else begin
      p4_q <= p3_q;
    end
    prod_r_q <= 24'(color_red) * 24'(ca_q);
    prod_g_q <= 24'(color_green) * 24'(ca_q);
    prod_b_q <= 24'(color_blue) * 24'(ca_q);
    alpha_q  <= ca_q[15:8];
  end

  // ---------------- P5: divide by 255*256, output register ----------------
  // floor(u/255) = (u + (u>>8) + 1) >> 8, exact while the quotient fits a byte
  function automatic logic [CHAN_W-1:0] div_65280(input logic [23:0] v);
    logic [16:0] s;
    s = 17'(v[23:8]) + 17'(v[23:16]) + 17'd1;
    return s[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= p4_q;
    end
    out_red   <= div_65280(prod_r_q);
    out_green <= div_65280(prod_g_q);
    out_blue  <= div_65280(prod_b_q);
    out_alpha <= alpha_q;
  end

endmodule

@@ rtl/arcp_checker.sv @@
module arcp_checker import arcp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [CHAN_W-1:0] out_red,
  input logic [CHAN_W-1:0] out_green,
  input logic [CHAN_W-1:0] out_blue,
  input logic [CHAN_W-1:0] out_alpha,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] prdata
);

  localparam int LATENCY = 7 + (FRAC_BITS + 8 + SQRT_STEPS - 1) / SQRT_STEPS;

  // every accepted transaction comes back after the fixed latency
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("accepted transaction produced no result");

  // no result without a matching accept
  a_done_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without accepted transaction");

  // premultiplied color never exceeds its alpha
  a_premult: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_red <= out_alpha && out_green <= out_alpha && out_blue <= out_alpha))
    else $error("premultiplied channel above alpha");

  // register readback only moves after a write or on an address change
  a_readback: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && $past(!(psel && penable && pwrite)) && $stable(paddr))
      |-> $stable(prdata))
    else $error("register readback changed without a write");

endmodule

bind antialiased_ring_corner_pixel arcp_checker #(.FRAC_BITS(FRAC_BITS)) u_arcp_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_alpha (out_alpha),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .prdata    (prdata)
);
